/* src/mva_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mva_pkg
// Shared types and constants for the MIDI voice allocator.
// ----------------------------------------------------------------------------
package mva_pkg;
  localparam int MAX_VOICES = 8;
  localparam int VW = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int CW = $clog2(MAX_VOICES + 1);
  localparam logic [15:0] AGE_RESET = 16'd1000;
  localparam logic [15:0] AGE_MAX = 16'hFFFF;
  localparam logic [7:0] ST_NOTE_OFF = 8'd128;
  localparam logic [7:0] ST_NOTE_ON = 8'd144;
  localparam logic [7:0] ST_BEND = 8'd224;

  localparam logic [1:0] CFG_MODE = 2'd0;
  localparam logic [1:0] CFG_MASK = 2'd1;
  localparam logic [1:0] CFG_COUNT = 2'd2;
  localparam logic [1:0] CFG_MAP = 2'd3;

  localparam logic [1:0] MODE_PIANO = 2'd0;
  localparam logic [1:0] MODE_PBEND = 2'd1;
  localparam logic [1:0] MODE_LEGATO = 2'd2;

  localparam logic [2:0] FN_ON = 3'd0;
  localparam logic [2:0] FN_OFF = 3'd1;
  localparam logic [2:0] FN_BEND = 3'd2;
  localparam logic [2:0] FN_PDOWN = 3'd3;
  localparam logic [2:0] FN_PUP = 3'd4;

  typedef struct packed {
    logic [2:0] func;
    logic [6:0] d1;
    logic [6:0] d2;
  } cmd_t;
endpackage
`default_nettype wire

/* src/mva_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mva_front
// Accepts events, drops masked and unused ones, queues the rest.
// ----------------------------------------------------------------------------
module mva_front import mva_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [2:0] in_func,
  input  wire logic [3:0] in_in_channel,
  input  wire logic [6:0] in_data_one,
  input  wire logic [6:0] in_data_two,
  input  wire logic [1:0] mode,
  input  wire logic [15:0] mask,
  output logic            q_valid,
  input  wire logic       q_ready,
  output cmd_t            q_cmd
);
  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, wr_r;
  logic keep, push, pop;

  always_comb begin
    keep = mask[in_in_channel];
    unique case (mode)
      MODE_PIANO:  keep = keep && (in_func <= FN_PUP) && (in_func != FN_BEND);
      MODE_PBEND:  keep = keep && (in_func <= FN_PUP);
      MODE_LEGATO: keep = keep && (in_func <= FN_BEND);
      default:     keep = 1'b0;
    endcase
  end

  assign in_ready = (cnt_r != 2'd2);
  assign push = in_valid && in_ready && keep;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_valid && q_ready;
  assign q_cmd = q_r[rd_r];
  assign cnt_nxt = cnt_r + {1'b0, push} - {1'b0, pop};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) wr_r <= ~wr_r;
      if (pop) rd_r <= ~rd_r;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= '{func: in_func, d1: in_data_one, d2: in_data_two};
  end

  a_cnt: assert property (@(posedge clk) disable iff (!rst_n) cnt_r <= 2'd2)
    else $error("queue overflow");
  a_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r == 2'd0 |-> !pop) else $error("pop on empty");
  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    push && !pop |=> cnt_r == $past(cnt_r) + 2'd1) else $error("count slip");
endmodule
`default_nettype wire

/* src/mva_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// mva_back
// Voice state and sequencer: one voice per cycle in scans; releases can stall.
// ----------------------------------------------------------------------------
module mva_back import mva_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  output logic             q_ready,
  input  cmd_t             q_cmd,
  input  wire logic [1:0]  mode,
  input  wire logic [4:0]  voice_count,
  input  wire logic [63:0] chan_map,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_status_byte,
  output logic [6:0]       out_data_one,
  output logic [6:0]       out_data_two,
  output logic             out_last
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_SCAN = 5'b00010,
    S_REL  = 5'b00100,
    S_AGE  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t st_r, st_nxt;
  logic [6:0] note_r [MAX_VOICES];
  logic [MAX_VOICES-1:0] pressed_r, playing_r;
  logic [15:0] age_r [MAX_VOICES];
  logic sus_r;
  logic [VW-1:0] cur_r;
  logic [7:0] sound_r;
  cmd_t cmd_r;
  logic [VW-1:0] idx_r;
  logic [15:0] best_r;
  logic [VW-1:0] bidx_r;
  logic pend_r;
  logic [7:0] pst_r;
  logic [6:0] pd1_r, pd2_r;
  logic [CW-1:0] n;
  logic [VW-1:0] curfix, nxtv;
  logic ob_free, last_idx, hit, rel, emit;

  always_comb begin
    if (voice_count == 5'd0) n = CW'(1);
    else if (voice_count > 5'(MAX_VOICES)) n = CW'(MAX_VOICES);
    else n = CW'(voice_count);
  end

  function automatic logic [7:0] chan(input logic [63:0] m, input logic [VW-1:0] v);
    chan = {4'd0, m[{2'd0, 4'(v)}*4 +: 4]};
  endfunction

  assign curfix = ({1'b0, cur_r} >= {1'b0, n}) ? '0 : cur_r;
  assign nxtv = ({1'b0, curfix} + 1'b1 >= {1'b0, n}) ? '0 : VW'(curfix + 1'b1);
  assign ob_free = !out_valid || out_ready;
  assign last_idx = ({1'b0, idx_r} + 1'b1 >= {1'b0, n});
  assign q_ready = (st_r == S_IDLE) && !pend_r;
  assign hit = (cmd_r.func == FN_OFF) ?
               (note_r[idx_r] == cmd_r.d1 && playing_r[idx_r]) :
               (!pressed_r[idx_r] && playing_r[idx_r]);
  assign rel = hit && !(cmd_r.func == FN_OFF && sus_r);
  // a release in the pass only flushes the previous note-off; the final one
  // leaves from S_DONE flagged last
  assign emit = pend_r && ob_free &&
                (st_r == S_IDLE || st_r == S_DONE || (st_r == S_REL && rel));

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (q_valid && q_ready) begin
        if ((q_cmd.func == FN_ON && mode == MODE_PIANO) ||
            (q_cmd.func == FN_BEND && mode == MODE_PBEND)) st_nxt = S_SCAN;
        else if (mode != MODE_LEGATO &&
                 (q_cmd.func == FN_OFF || q_cmd.func == FN_PUP)) st_nxt = S_REL;
      end
      S_SCAN: if (last_idx) st_nxt = S_DONE;
      S_REL: begin
        if (rel && pend_r && !ob_free) st_nxt = S_REL;
        else if (rel) st_nxt = S_AGE;
        else if (last_idx) st_nxt = S_DONE;
      end
      S_AGE: st_nxt = last_idx ? S_DONE : S_REL;
      S_DONE: if (!pend_r || ob_free) st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      out_valid <= 1'b0;
      pend_r <= 1'b0;
      pressed_r <= '0;
      playing_r <= '0;
      sus_r <= 1'b0;
      cur_r <= '0;
      sound_r <= '0;
      for (int i = 0; i < MAX_VOICES; i++) begin
        note_r[i] <= '0;
        age_r[i] <= AGE_RESET;
      end
    end else begin
      st_r <= st_nxt;
      unique case (st_r)
        S_IDLE: if (q_valid && q_ready) begin
          cmd_r <= q_cmd;
          idx_r <= '0;
          best_r <= '0;
          bidx_r <= '0;
          if (mode == MODE_PBEND && q_cmd.func == FN_ON) begin
            cur_r <= curfix;
            note_r[curfix] <= q_cmd.d1;
            pressed_r[curfix] <= 1'b1;
            playing_r[curfix] <= 1'b1;
            age_r[curfix] <= '0;
            pend_r <= 1'b1;
            pst_r <= ST_NOTE_ON + chan(chan_map, curfix);
            pd1_r <= q_cmd.d1;
            pd2_r <= q_cmd.d2;
          end else if (mode != MODE_LEGATO && q_cmd.func == FN_PDOWN) begin
            sus_r <= 1'b1;
          end else if (mode != MODE_LEGATO && q_cmd.func == FN_PUP) begin
            sus_r <= 1'b0;
          end else if (mode == MODE_LEGATO) begin
            pend_r <= 1'b1;
            pd1_r <= q_cmd.d1;
            pd2_r <= q_cmd.d2;
            unique case (q_cmd.func)
              FN_ON: begin
                cur_r <= curfix;
                if (sound_r != 8'hFF) sound_r <= sound_r + 8'd1;
                note_r[curfix] <= q_cmd.d1;
                pst_r <= ST_NOTE_ON + chan(chan_map, curfix);
              end
              FN_OFF: begin
                cur_r <= curfix;
                if (sound_r != 8'd0) sound_r <= sound_r - 8'd1;
                pst_r <= ST_NOTE_OFF + chan(chan_map, curfix);
              end
              default: begin
                if (sound_r == 8'd0) begin
                  cur_r <= nxtv;
                  pst_r <= ST_BEND + chan(chan_map, nxtv);
                end else begin
                  cur_r <= curfix;
                  pst_r <= ST_BEND + chan(chan_map, curfix);
                end
              end
            endcase
          end
        end
        S_SCAN: begin
          if (age_r[idx_r] > best_r) begin
            best_r <= age_r[idx_r];
            bidx_r <= idx_r;
          end
          idx_r <= idx_r + 1'b1;
        end
        S_REL: if (!(rel && pend_r && !ob_free)) begin
          if (hit && cmd_r.func == FN_OFF) pressed_r[idx_r] <= 1'b0;
          if (rel) begin
            playing_r[idx_r] <= 1'b0;
            age_r[idx_r] <= '0;
            pend_r <= 1'b1;
            pst_r <= ST_NOTE_OFF + chan(chan_map, idx_r);
            pd1_r <= (cmd_r.func == FN_OFF) ? cmd_r.d1 : note_r[idx_r];
            pd2_r <= (cmd_r.func == FN_OFF) ? cmd_r.d2 : 7'd0;
          end else begin
            idx_r <= idx_r + 1'b1;
          end
        end
        S_AGE: begin
          for (int j = 0; j < MAX_VOICES; j++) begin
            if (j < int'(n) && !playing_r[j] && age_r[j] != AGE_MAX)
              age_r[j] <= age_r[j] + 16'd1;
          end
          idx_r <= idx_r + 1'b1;
        end
        S_DONE: begin
          if (cmd_r.func == FN_ON && mode == MODE_PIANO && !pend_r) begin
            cur_r <= bidx_r;
            note_r[bidx_r] <= cmd_r.d1;
            pressed_r[bidx_r] <= 1'b1;
            playing_r[bidx_r] <= 1'b1;
            age_r[bidx_r] <= '0;
            pend_r <= 1'b1;
            pst_r <= ST_NOTE_ON + chan(chan_map, bidx_r);
            pd1_r <= cmd_r.d1;
            pd2_r <= cmd_r.d2;
          end else if (cmd_r.func == FN_BEND && mode == MODE_PBEND && !pend_r) begin
            cur_r <= bidx_r;
            pend_r <= 1'b1;
            pst_r <= ST_BEND + chan(chan_map, bidx_r);
            pd1_r <= cmd_r.d1;
            pd2_r <= cmd_r.d2;
          end else if (pend_r && ob_free) begin
            pend_r <= 1'b0;
          end
        end
        default: ;
      endcase
      if (st_r == S_IDLE && pend_r && ob_free) pend_r <= 1'b0;
      if (emit) begin
        out_valid <= 1'b1;
        out_status_byte <= pst_r;
        out_data_one <= pd1_r;
        out_data_two <= pd2_r;
        out_last <= (st_r != S_REL);
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid) else $error("output dropped");
  a_idle_q: assert property (@(posedge clk) disable iff (!rst_n)
    q_ready |-> st_r == S_IDLE && !pend_r) else $error("ready while busy");
  a_cur: assert property (@(posedge clk) disable iff (!rst_n)
    $past(st_r) == S_AGE |-> !playing_r[$past(idx_r)]) else $error("release lost");
endmodule
`default_nettype wire

/* src/midi_voice_allocator.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// midi_voice_allocator
// Spreads classified MIDI events over output voices.
// ----------------------------------------------------------------------------
// Channel  Handshake            Payload
// in       in_valid/in_ready    func, in_channel, data_one, data_two
// out      out_valid/out_ready  status_byte, data bytes, last
// cfg      cfg_we               cfg_index, cfg_data
// A note-on scan (piano) or bend scan (bend mode) walks the voices one per
// cycle; a release pass walks them too, each released voice also taking an
// aging step. Reset is synchronous.
// A two-entry queue decouples input from the sequencer; the sequencer stalls
// on a full output register.
module midi_voice_allocator import mva_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [2:0]  in_func,
  input  wire logic [3:0]  in_in_channel,
  input  wire logic [6:0]  in_data_one,
  input  wire logic [6:0]  in_data_two,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [7:0]       out_status_byte,
  output logic [6:0]       out_out_data_one,
  output logic [6:0]       out_out_data_two,
  output logic             out_last,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [63:0] cfg_data
);
  logic [1:0] mode_r;
  logic [15:0] mask_r;
  logic [4:0] cnt_r;
  logic [63:0] map_r;
  logic q_valid, q_ready;
  cmd_t q_cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= '0;
      mask_r <= '0;
      cnt_r <= 5'd1;
      map_r <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_MODE:  mode_r <= cfg_data[1:0];
        CFG_MASK:  mask_r <= cfg_data[15:0];
        CFG_COUNT: cnt_r <= cfg_data[4:0];
        CFG_MAP:   map_r <= cfg_data;
        default: ;
      endcase
    end
  end

  mva_front u_front (
    .clk, .rst_n, .in_valid, .in_ready, .in_func, .in_in_channel,
    .in_data_one, .in_data_two, .mode(mode_r), .mask(mask_r),
    .q_valid, .q_ready, .q_cmd
  );

  mva_back u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd, .mode(mode_r),
    .voice_count(cnt_r), .chan_map(map_r), .out_valid, .out_ready,
    .out_status_byte, .out_data_one(out_out_data_one),
    .out_data_two(out_out_data_two), .out_last
  );
endmodule
`default_nettype wire
